/* hw/rtl/assert_macros.svh */
// Assertion macros for the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CHK_IMPLY(lbl, ck, rs, a, b) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |-> (b)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define CHK_NEXT(lbl, ck, rs, a, b) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |=> (b)) \
    else $error("next-cycle check failed");

`endif

/* hw/rtl/qsh_pkg.sv */
// Shared types, constants and the LCG step of the short-header generator.
package qsh_pkg;

  localparam int LEN_W  = 7;
  localparam int IDX_W  = 6;
  localparam int SEED_W = 32;

  localparam logic [31:0] FNV_BASIS = 32'h811c_9dc5;
  localparam logic [31:0] FNV_PRIME = 32'h0100_0193;
  localparam logic [31:0] LCG_MUL   = 32'd1103515245;
  localparam logic [31:0] LCG_ADD   = 32'd12345;
  localparam logic [7:0]  QUIC_FIXED_BIT = 8'h40;

  typedef enum logic [2:0] {
    PROTO_NONE = 3'd0,
    PROTO_QUIC = 3'd1,
    PROTO_DNS  = 3'd2,
    PROTO_STUN = 3'd3,
    PROTO_SIP  = 3'd4
  } proto_t;

  typedef enum logic {
    OP_HASH = 1'b0,
    OP_FILL = 1'b1
  } opcode_t;

  // register index, taken from paddr[2]
  localparam logic REG_PROTOCOL = 1'b0;

  typedef struct packed {
    logic [SEED_W-1:0] seed;
    logic [LEN_W-1:0]  len;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_PREP = 2'd1,
    BK_EMIT = 2'd2
  } bk_state_t;

  function automatic logic [31:0] lcg_next(input logic [31:0] s);
    logic [31:0] prod;
    prod = s * LCG_MUL;
    return prod + LCG_ADD;
  endfunction

endpackage

/* hw/rtl/qsh_front.sv */
// Front end: accept items, keep the FNV-1a hash, queue fill and end-of-packet jobs.
module qsh_front
  import qsh_pkg::*;
#(
  parameter int MAX_PREFIX = 64,
  parameter int HASH_BYTES = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              opcode,
  input  logic [7:0]        data_byte,
  input  logic              last,
  input  logic [LEN_W-1:0]  length,
  input  logic [SEED_W-1:0] seed,
  input  logic [2:0]        protocol,
  input  qstat_t            q_stat,
  output logic              push,
  output job_t              job
);

  localparam int CNT_W = $clog2(HASH_BYTES + 1);

  logic [31:0]      hash;
  logic [CNT_W-1:0] hashed_count;
  logic [31:0]      hash_upd;
  logic [31:0]      hash_eff;
  logic             do_hash;
  logic             accept;
  logic [LEN_W-1:0] len_sat;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;
  assign do_hash  = hashed_count < CNT_W'(HASH_BYTES);
  assign hash_upd = (hash ^ {24'b0, data_byte}) * FNV_PRIME;
  assign hash_eff = do_hash ? hash_upd : hash;
  assign len_sat  = (length > LEN_W'(MAX_PREFIX)) ? LEN_W'(MAX_PREFIX) : length;

  // a job only for an emitting item: fill, or last payload byte, quic, nonzero length
  assign push = accept && (protocol == PROTO_QUIC) && (len_sat != '0)
                && ((opcode == OP_FILL) || last);
  assign job.seed = (opcode == OP_FILL) ? seed : hash_eff;
  assign job.len  = len_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      hash         <= FNV_BASIS;
      hashed_count <= '0;
    end else if (accept && (opcode == OP_HASH)) begin
      if (last) begin
        hash         <= FNV_BASIS;
        hashed_count <= '0;
      end else if (do_hash) begin
        hash         <= hash_upd;
        hashed_count <= hashed_count + CNT_W'(1);
      end
    end
  end

endmodule

/* hw/rtl/qsh_queue.sv */
// Two-entry job queue between front and back ends.
module qsh_queue
  import qsh_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  job_t   wr_job,
  input  logic   pop,
  output job_t   rd_job,
  output qstat_t q_stat
);

  job_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign rd_job       = entries[rd_ptr];
  assign q_stat.full  = (count == 2'd2);
  assign q_stat.empty = (count == 2'd0);

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* hw/rtl/qsh_back.sv */
// Back end: run the LCG for a job and emit the prefix bytes.
module qsh_back
  import qsh_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  qstat_t           q_stat,
  input  job_t             job,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_byte,
  output logic [IDX_W-1:0] out_index,
  output logic             out_last
);

  bk_state_t        state, state_next;
  logic [31:0]      s;
  logic [31:0]      s_step;
  logic             spin, kp;
  logic [1:0]       pn;
  logic [1:0]       prep_cnt;
  logic [IDX_W-1:0] pos;
  logic [LEN_W-1:0] len;
  logic             emit_go;
  logic             final_byte;
  logic [7:0]       hdr_byte;

  assign s_step     = lcg_next(s);
  assign final_byte = (LEN_W'(pos) + LEN_W'(1)) == len;
  assign hdr_byte   = QUIC_FIXED_BIT | {2'b00, spin, 2'b00, kp, pn};

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: if (!q_stat.empty) state_next = BK_PREP;
      BK_PREP: if (prep_cnt == 2'd2) state_next = BK_EMIT;
      BK_EMIT: if (emit_go && final_byte) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    pop     = 1'b0;
    emit_go = 1'b0;
    case (state)
      BK_IDLE: pop = !q_stat.empty;
      BK_EMIT: emit_go = !out_valid || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit_go)        out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      BK_IDLE: begin
        if (pop) begin
          s        <= job.seed;
          spin     <= job.seed[8];
          len      <= job.len;
          prep_cnt <= 2'd0;
          pos      <= '0;
        end
      end
      BK_PREP: begin
        s        <= s_step;
        prep_cnt <= prep_cnt + 2'd1;
        if (prep_cnt == 2'd0) kp <= s_step[8];
        if (prep_cnt == 2'd1) pn <= s_step[1:0];
      end
      BK_EMIT: begin
        if (emit_go) begin
          out_byte  <= (pos == '0) ? hdr_byte : s[23:16];
          out_index <= pos;
          out_last  <= final_byte;
          pos       <= pos + IDX_W'(1);
          if (pos != '0) s <= s_step;
        end
      end
      default: ;
    endcase
  end

endmodule

/* hw/rtl/quic_short_header_imitation.sv */
// Top level of the QUIC short-header imitation prefix generator.
// Payload bytes are taken one per cycle while the job queue has room.
// A fill goes from acceptance to its first byte through the queue, the pop and
// three LCG steps, then one byte per cycle while out_ready does not stall it.
// Synchronous active-high reset clears hash, queue, sequencer and protocol.
`include "assert_macros.svh"

module quic_short_header_imitation
  import qsh_pkg::*;
#(
  parameter int MAX_PREFIX = 64,
  parameter int HASH_BYTES = 64
) (
  input  logic              clk,
  input  logic              rst,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  // input items
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              opcode,
  input  logic [7:0]        data_byte,
  input  logic              last,
  input  logic [LEN_W-1:0]  length,
  input  logic [SEED_W-1:0] seed,
  // result items
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic [IDX_W-1:0]  out_index,
  output logic              out_last
);

  logic [2:0] protocol;
  logic       job_push;
  logic       job_pop;
  job_t       wr_job;
  job_t       rd_job;
  qstat_t     q_stat;

  // Register file: a single protocol register at byte address 0.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_PROTOCOL) ? {29'b0, protocol} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      protocol <= PROTO_NONE;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_PROTOCOL)) begin
      protocol <= pwdata[2:0];
    end
  end

  // Front end hashes payload and turns each emitting item into a job.
  qsh_front #(
    .MAX_PREFIX (MAX_PREFIX),
    .HASH_BYTES (HASH_BYTES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .opcode    (opcode),
    .data_byte (data_byte),
    .last      (last),
    .length    (length),
    .seed      (seed),
    .protocol  (protocol),
    .q_stat    (q_stat),
    .push      (job_push),
    .job       (wr_job)
  );

  // Hold pending jobs so hashing of the next packet can overlap emission.
  qsh_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (job_push),
    .wr_job (wr_job),
    .pop    (job_pop),
    .rd_job (rd_job),
    .q_stat (q_stat)
  );

  // Back end steps the LCG and drives the registered output item.
  qsh_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_stat    (q_stat),
    .job       (rd_job),
    .pop       (job_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .out_index (out_index),
    .out_last  (out_last)
  );

  // A job is never pushed into a full queue.
  `CHK_IMPLY(a_no_overflow, clk, rst, job_push, !q_stat.full)
  // The first byte of a prefix always carries the short-header fixed bits.
  `CHK_IMPLY(a_hdr_bits, clk, rst, out_valid && (out_index == '0), out_byte[7:6] == 2'b01)
  // Within a prefix the next byte follows at once with the next index.
  `CHK_NEXT(a_idx_step, clk, rst, out_valid && out_ready && !out_last, out_valid && (out_index == $past(out_index) + IDX_W'(1)))

endmodule

/* verif/tb.sv */
// Self-checking testbench for the QUIC short-header imitation prefix generator.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import qsh_pkg::*;

  localparam int MAX_PREFIX = 64;
  localparam int HASH_BYTES = 64;
  // protocol code with no name: the top of the 3-bit register
  localparam logic [2:0] PROTO_TOP = 3'd7;
  localparam logic [2:0] PROTOCOL_ADDR = {REG_PROTOCOL, 2'b00};
  localparam int NO_WRITE = -1;        // row leaves the protocol alone
  localparam int PREDICTED_ONLY = -1;  // row has no typed result count
  localparam int SETTLE_CYCLES = 16;   // covers queue, pop and three LCG steps
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int PRESSURE_FILLS = 16;

  typedef struct {
    logic [7:0]       out_byte;
    logic [IDX_W-1:0] out_index;
    logic             out_last;
  } prefix_byte_t;

  // one row of the directed table
  typedef struct {
    int               set_proto;  // protocol written before the row, or NO_WRITE
    opcode_t          op;
    logic [7:0]       data;
    logic             lst;
    logic [LEN_W-1:0] len;
    logic [31:0]      sd;
    int               n_typed;    // bytes the row must emit, or PREDICTED_ONLY
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [2:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              opcode = OP_HASH;
  logic [7:0]        data_byte = '0;
  logic              last = 1'b0;
  logic [LEN_W-1:0]  length = '0;
  logic [SEED_W-1:0] seed = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [7:0]        out_byte;
  logic [IDX_W-1:0]  out_index;
  logic              out_last;

  // Own copy of the block's state, updated as items are accepted.
  logic [2:0]   model_protocol = PROTO_NONE;
  logic [31:0]  pkt_hash = FNV_BASIS;
  int           hashed = 0;
  prefix_byte_t prefix_q[$];   // bytes still owed by the block, oldest first

  int sender_idle_pct = 0;
  int stall_pct = 0;
  int hold_req = 0;
  int hold_left = 0;

  int errors = 0;
  int items_sent = 0;
  int packets = 0;
  int fills = 0;
  int stray = 0;
  int bytes_checked = 0;
  int predicted_total = 0;
  int proto_writes = 0;

  stim_row_t directed_rows [19] = '{
    // after reset the protocol is none: nothing comes out
    '{NO_WRITE,   OP_FILL, 8'h00, 1'b0, 7'd5,   32'h0000_0000, 0},
    '{NO_WRITE,   OP_HASH, 8'hFF, 1'b1, 7'd64,  32'h0000_0000, 0},
    // quic: zero length, one byte, full, saturated lengths
    '{PROTO_QUIC, OP_FILL, 8'h00, 1'b0, 7'd0,   32'hFFFF_FFFF, 0},
    '{NO_WRITE,   OP_FILL, 8'h00, 1'b0, 7'd1,   32'h0000_0000, 1},
    '{NO_WRITE,   OP_FILL, 8'hFF, 1'b0, 7'd64,  32'hFFFF_FFFF, 64},
    '{NO_WRITE,   OP_FILL, 8'h00, 1'b0, 7'd127, 32'h0000_0100, 64},
    '{NO_WRITE,   OP_FILL, 8'h00, 1'b0, 7'd65,  32'hA5A5_A5A5, 64},
    // last is ignored on a fill
    '{NO_WRITE,   OP_FILL, 8'h00, 1'b1, 7'd2,   32'h5A5A_5A5A, 2},
    // open a packet, drop a fill into it, then close it
    '{NO_WRITE,   OP_HASH, 8'h00, 1'b0, 7'd127, 32'hFFFF_FFFF, 0},
    '{NO_WRITE,   OP_HASH, 8'hFF, 1'b0, 7'd0,   32'h0000_0000, 0},
    '{NO_WRITE,   OP_FILL, 8'h00, 1'b1, 7'd3,   32'h1234_5678, 3},
    '{NO_WRITE,   OP_HASH, 8'h5A, 1'b1, 7'd4,   32'h0000_0000, 4},
    // one-byte packets: zero, full and saturated prefix lengths
    '{NO_WRITE,   OP_HASH, 8'h7E, 1'b1, 7'd0,   32'h0000_0000, 0},
    '{NO_WRITE,   OP_HASH, 8'h01, 1'b1, 7'd64,  32'h0000_0000, 64},
    '{NO_WRITE,   OP_HASH, 8'h80, 1'b1, 7'd100, 32'h0000_0000, 64},
    // sip: hashing and the end-of-packet reset still happen, no output
    '{PROTO_SIP,  OP_FILL, 8'h00, 1'b0, 7'd8,   32'h0000_0000, 0},
    '{NO_WRITE,   OP_HASH, 8'h33, 1'b0, 7'd8,   32'h0000_0000, 0},
    '{NO_WRITE,   OP_HASH, 8'h44, 1'b1, 7'd8,   32'h0000_0000, 0},
    // back to quic: this packet must hash from the offset basis
    '{PROTO_QUIC, OP_HASH, 8'h44, 1'b1, 7'd8,   32'h0000_0000, 8}
  };

  quic_short_header_imitation u_dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .opcode    (opcode),
    .data_byte (data_byte),
    .last      (last),
    .length    (length),
    .seed      (seed),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .out_index (out_index),
    .out_last  (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [31:0] lcg_advance(input logic [31:0] s);
    return s * LCG_MUL + LCG_ADD;
  endfunction

  // Queue the prefix the block owes for a length and a seed.
  task automatic expect_prefix(input logic [LEN_W-1:0] req_len, input logic [31:0] seed_in);
    int           n;
    logic [31:0]  st;
    logic         spin_bit;
    logic         phase_bit;
    logic [1:0]   pn_len;
    prefix_byte_t b;
    n = (req_len > MAX_PREFIX) ? MAX_PREFIX : int'(req_len);
    if (n == 0 || model_protocol != PROTO_QUIC) return;
    // spin from the seed, key phase and packet-number length from the next two states
    spin_bit = seed_in[8];
    st = lcg_advance(seed_in);
    phase_bit = st[8];
    st = lcg_advance(st);
    pn_len = st[1:0];
    st = lcg_advance(st);
    for (int i = 0; i < n; i++) begin
      if (i == 0) begin
        b.out_byte = QUIC_FIXED_BIT | {2'b00, spin_bit, 2'b00, phase_bit, pn_len};
      end else begin
        b.out_byte = st[23:16];
        st = lcg_advance(st);
      end
      b.out_index = IDX_W'(i);
      b.out_last = (i == n - 1);
      prefix_q.push_back(b);
      predicted_total++;
    end
  endtask

  // Advance the model by one accepted item.
  task automatic model_item(input opcode_t op, input logic [7:0] d, input logic lst,
                            input logic [LEN_W-1:0] ln, input logic [31:0] sd);
    if (op == OP_FILL) begin
      expect_prefix(ln, sd);
      return;
    end
    // only the first bytes of a packet feed the FNV-1a hash
    if (hashed < HASH_BYTES) begin
      pkt_hash = (pkt_hash ^ {24'h0, d}) * FNV_PRIME;
      hashed++;
    end
    if (lst) begin
      expect_prefix(ln, pkt_hash);
      pkt_hash = FNV_BASIS;
      hashed = 0;
    end
  endtask

  // Offer one item and hold it until accepted. Valid stays high afterwards so
  // that back-to-back items never drop it; the next gap or settle lowers it.
  task automatic push_item(input opcode_t op, input logic [7:0] d, input logic lst,
                           input logic [LEN_W-1:0] ln, input logic [31:0] sd);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    opcode    <= op;
    data_byte <= d;
    last      <= lst;
    length    <= ln;
    seed      <= sd;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    model_item(op, d, lst, ln, sd);
  endtask

  // Drop valid, wait for every owed byte, then let the pipeline go quiet.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (prefix_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the protocol register, then read it back. Call only when idle.
  task automatic write_protocol(input logic [2:0] value);
    logic [31:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PROTOCOL_ADDR;
    pwdata  <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    // the register takes the value at this edge
    model_protocol = value;
    proto_writes++;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd[2:0] !== value) begin
      $error("protocol readback: expected %0d, actual %0d", value, rd[2:0]);
      errors++;
    end
  endtask

  // Mostly short prefixes, with zero, the full size and oversize lengths mixed in.
  function automatic logic [LEN_W-1:0] draw_length();
    int r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 75) return LEN_W'($urandom_range(8, 1));
    if (r < 88) return LEN_W'($urandom_range(63, 9));
    if (r < 95) return LEN_W'(MAX_PREFIX);
    return LEN_W'($urandom_range(127, 65));
  endfunction

  // Random stimulus: well-formed packets, direct fills and stray unfinished bytes.
  task automatic run_random_phase(input logic [2:0] proto, input int idle_pct,
                                  input int stall, input int n_items, input bit pause_midway);
    int sent_here;
    int kind;
    int nbytes;
    bit paused;
    settle();
    write_protocol(proto);
    sender_idle_pct = idle_pct;
    stall_pct = stall;
    sent_here = 0;
    paused = 1'b0;
    while (sent_here < n_items) begin
      // hold the sender until the block has delivered everything it owes
      if (pause_midway && !paused && sent_here >= n_items / 2) begin
        paused = 1'b1;
        in_valid <= 1'b0;
        @(posedge clk);
        while (prefix_q.size() != 0) @(posedge clk);
      end
      kind = $urandom_range(99);
      if (kind < 55) begin
        // some packets run past the hashed window
        nbytes = ($urandom_range(9) == 0) ? $urandom_range(80, 60) : $urandom_range(12, 1);
        for (int k = 1; k <= nbytes; k++)
          push_item(OP_HASH, 8'($urandom), k == nbytes, draw_length(), $urandom);
        sent_here += nbytes;
        packets++;
      end else if (kind < 85) begin
        push_item(OP_FILL, 8'($urandom), 1'($urandom), draw_length(), $urandom);
        sent_here++;
        fills++;
      end else begin
        // broken packet: bytes with no last, they run into whatever follows
        nbytes = $urandom_range(4, 1);
        for (int k = 0; k < nbytes; k++)
          push_item(OP_HASH, 8'($urandom), 1'b0, LEN_W'($urandom), $urandom);
        sent_here += nbytes;
        stray += nbytes;
      end
    end
  endtask

  // Receiver: check each accepted byte, then pick out_ready for the next cycle.
  always @(posedge clk) begin : result_check
    prefix_byte_t exp_b;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        bytes_checked++;
        if (prefix_q.size() == 0) begin
          $error("unexpected byte %02h at index %0d", out_byte, out_index);
          errors++;
        end else begin
          exp_b = prefix_q.pop_front();
          if (out_byte !== exp_b.out_byte) begin
            $error("out_byte: expected %02h, actual %02h", exp_b.out_byte, out_byte);
            errors++;
          end
          if (out_index !== exp_b.out_index) begin
            $error("out_index: expected %0d, actual %0d", exp_b.out_index, out_index);
            errors++;
          end
          if (out_last !== exp_b.out_last) begin
            $error("out_last: expected %0d, actual %0d", exp_b.out_last, out_last);
            errors++;
          end
        end
      end
      // a long hold-off, when requested, beats the random stall
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin : stimulus
    int total_at_row;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table, no idling on either side
    foreach (directed_rows[i]) begin
      if (directed_rows[i].set_proto != NO_WRITE) begin
        settle();
        write_protocol(3'(directed_rows[i].set_proto));
      end
      total_at_row = predicted_total;
      push_item(directed_rows[i].op, directed_rows[i].data, directed_rows[i].lst,
                directed_rows[i].len, directed_rows[i].sd);
      if (directed_rows[i].n_typed != PREDICTED_ONLY &&
          predicted_total - total_at_row != directed_rows[i].n_typed) begin
        $error("row %0d byte count: expected %0d, actual %0d", i,
               directed_rows[i].n_typed, predicted_total - total_at_row);
        errors++;
      end
    end

    // back pressure: stop the receiver and offer PRESSURE_FILLS full-size fills,
    // enough that the block stalls its input
    settle();
    sender_idle_pct = 0;
    stall_pct = 0;
    hold_req = HOLD_OFF_CYCLES;
    for (int k = 0; k < PRESSURE_FILLS; k++) begin
      push_item(OP_FILL, 8'($urandom), 1'b0, LEN_W'(MAX_PREFIX), $urandom);
      fills++;
    end

    run_random_phase(PROTO_QUIC, 0,  0,  60, 1'b0);
    run_random_phase(PROTO_QUIC, 54, 0,  60, 1'b1);
    run_random_phase(PROTO_DNS,  0,  54, 20, 1'b0);
    run_random_phase(PROTO_QUIC, 0,  54, 60, 1'b0);
    run_random_phase(PROTO_TOP,  30, 30, 20, 1'b0);
    run_random_phase(PROTO_NONE, 54, 0,  15, 1'b0);
    run_random_phase(PROTO_QUIC, 30, 30, 60, 1'b0);

    settle();
    $display("Covered %0d items: %0d packets, %0d direct fills, %0d stray bytes.",
             items_sent, packets, fills, stray);
    $display("Checked %0d prefix bytes over %0d protocol writes and a %0d-cycle hold-off.",
             bytes_checked, proto_writes, HOLD_OFF_CYCLES);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog, many times the slowest legal run.
  initial begin : watchdog
    #5ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
